### rtl/core/cell_balance_poll_sequencer_macros.svh
// Assertion macros for the cell balance poll sequencer RTL.
`ifndef CELL_BALANCE_POLL_SEQUENCER_MACROS_SVH
`define CELL_BALANCE_POLL_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/cbps_pkg.sv
// Types and constants for the cell balance poll sequencer.
`timescale 1ns / 1ps

package cbps_pkg;

   typedef enum logic [2:0] {
      REG_MODULE_COUNT   = 3'd0,
      REG_BALANCE_ENABLE = 3'd1,
      REG_BALANCE_START  = 3'd2,
      REG_SPREAD_HYST    = 3'd3,
      REG_TARGET_OFFSET  = 3'd4,
      REG_BURST_MS       = 3'd5,
      REG_REST_MS        = 3'd6,
      REG_SETTLE_MS      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [4:0]  module_count;
      logic        balance_enable;
      logic [13:0] balance_start_mv;
      logic [13:0] spread_hysteresis_mv;
      logic [13:0] target_offset_mv;
      logic [31:0] burst_ms;
      logic [31:0] rest_ms;
      logic [31:0] settle_ms;
   } cfg_type;

   typedef struct packed {
      logic        burst_phase;
      logic [31:0] phase_start_ms;
      logic [31:0] burst_end_ms;
      logic        burst_ended;
      logic [15:0] target_mv;
   } duty_state_type;

   localparam logic [4:0]  RST_MODULE_COUNT   = 5'd6;
   localparam logic        RST_BALANCE_ENABLE = 1'b1;
   localparam logic [13:0] RST_BALANCE_START  = 14'd3900;
   localparam logic [13:0] RST_SPREAD_HYST    = 14'd20;
   localparam logic [13:0] RST_TARGET_OFFSET  = 14'd10;
   localparam logic [31:0] RST_BURST_MS       = 32'd60000;
   localparam logic [31:0] RST_REST_MS        = 32'd60000;
   localparam logic [31:0] RST_SETTLE_MS      = 32'd10000;

   localparam logic [7:0] FRAME_ID_BASE   = 8'h80;
   localparam logic [7:0] IDLE_TARGET_LO  = 8'hC7;
   localparam logic [7:0] IDLE_TARGET_HI  = 8'h10;
   localparam logic [7:0] CMD_STARTUP     = 8'h20;
   localparam logic [7:0] CMD_BALANCE_ON  = 8'h48;
   localparam logic [7:0] CMD_BALANCE_OFF = 8'h40;
   localparam logic [7:0] RUN_FLAG        = 8'h01;
   localparam logic [7:0] STARTUP_MARK    = 8'h04;
   localparam logic [3:0] CYCLE_WRAP      = 4'hF;
   localparam logic [3:0] STARTUP_EXIT_CYCLE = 4'd2;

endpackage

### rtl/core/cbps_csr.sv
// APB-style configuration register file for the poll sequencer.
`timescale 1ns / 1ps

module cbps_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cbps_pkg::cfg_type     cfg
);

   cbps_pkg::cfg_type       cfg_ff;
   cbps_pkg::cfg_type       cfg_in;
   cbps_pkg::csr_index_type idx;
   logic                    wr_en;

   assign idx        = cbps_pkg::csr_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            cbps_pkg::REG_MODULE_COUNT:   cfg_in.module_count = csr_pwdata[4:0];
            cbps_pkg::REG_BALANCE_ENABLE: cfg_in.balance_enable = csr_pwdata[0];
            cbps_pkg::REG_BALANCE_START:  cfg_in.balance_start_mv = csr_pwdata[13:0];
            cbps_pkg::REG_SPREAD_HYST:    cfg_in.spread_hysteresis_mv = csr_pwdata[13:0];
            cbps_pkg::REG_TARGET_OFFSET:  cfg_in.target_offset_mv = csr_pwdata[13:0];
            cbps_pkg::REG_BURST_MS:       cfg_in.burst_ms = csr_pwdata;
            cbps_pkg::REG_REST_MS:        cfg_in.rest_ms = csr_pwdata;
            cbps_pkg::REG_SETTLE_MS:      cfg_in.settle_ms = csr_pwdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         cbps_pkg::REG_MODULE_COUNT:   csr_prdata = {27'd0, cfg_ff.module_count};
         cbps_pkg::REG_BALANCE_ENABLE: csr_prdata = {31'd0, cfg_ff.balance_enable};
         cbps_pkg::REG_BALANCE_START:  csr_prdata = {18'd0, cfg_ff.balance_start_mv};
         cbps_pkg::REG_SPREAD_HYST:    csr_prdata = {18'd0, cfg_ff.spread_hysteresis_mv};
         cbps_pkg::REG_TARGET_OFFSET:  csr_prdata = {18'd0, cfg_ff.target_offset_mv};
         cbps_pkg::REG_BURST_MS:       csr_prdata = cfg_ff.burst_ms;
         cbps_pkg::REG_REST_MS:        csr_prdata = cfg_ff.rest_ms;
         cbps_pkg::REG_SETTLE_MS:      csr_prdata = cfg_ff.settle_ms;
         default:                      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.module_count         <= cbps_pkg::RST_MODULE_COUNT;
         cfg_ff.balance_enable       <= cbps_pkg::RST_BALANCE_ENABLE;
         cfg_ff.balance_start_mv     <= cbps_pkg::RST_BALANCE_START;
         cfg_ff.spread_hysteresis_mv <= cbps_pkg::RST_SPREAD_HYST;
         cfg_ff.target_offset_mv     <= cbps_pkg::RST_TARGET_OFFSET;
         cfg_ff.burst_ms             <= cbps_pkg::RST_BURST_MS;
         cfg_ff.rest_ms              <= cbps_pkg::RST_REST_MS;
         cfg_ff.settle_ms            <= cbps_pkg::RST_SETTLE_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/cbps_duty.sv
// Rest/burst duty decision and settle-window check for one poll transaction.
`timescale 1ns / 1ps

module cbps_duty #(
   parameter int NO_READING_MV = 10000
) (
   input  cbps_pkg::cfg_type         cfg,
   input  logic                      sweep_start,
   input  logic [31:0]               now_ms,
   input  logic [13:0]               highest_mv,
   input  logic [13:0]               lowest_mv,
   input  logic                      all_reported,
   input  cbps_pkg::duty_state_type  state_cur,
   output cbps_pkg::duty_state_type  state_next,
   output logic                      suspect
);

   localparam logic [13:0] NoReading = 14'(NO_READING_MV);

   logic [31:0] phase_elapsed;
   logic [31:0] since_end;
   logic [13:0] spread;
   logic        start_wanted;
   logic        just_ended;

   assign phase_elapsed = now_ms - state_cur.phase_start_ms;
   assign since_end     = now_ms - state_cur.burst_end_ms;
   assign spread        = highest_mv - lowest_mv;

   assign start_wanted = all_reported && (highest_mv != 14'd0) && (lowest_mv != NoReading)
                         && (highest_mv >= lowest_mv)
                         && (highest_mv > cfg.balance_start_mv)
                         && (spread > cfg.spread_hysteresis_mv);

   always_comb begin
      state_next = state_cur;
      just_ended = 1'b0;
      if (sweep_start) begin
         if (!cfg.balance_enable) begin
            state_next.burst_phase = 1'b0;
         end else if (state_cur.burst_phase) begin
            if (phase_elapsed >= cfg.burst_ms) begin
               state_next.burst_phase    = 1'b0;
               state_next.phase_start_ms = now_ms;
               state_next.burst_end_ms   = now_ms;
               state_next.burst_ended    = 1'b1;
               just_ended                = 1'b1;
            end
         end else if (phase_elapsed >= cfg.rest_ms) begin
            if (start_wanted) begin
               state_next.target_mv   = {2'b00, lowest_mv} + {2'b00, cfg.target_offset_mv};
               state_next.burst_phase = 1'b1;
            end
            state_next.phase_start_ms = now_ms;
         end
      end
   end

   // a burst ending on this tick gives zero elapsed time since its end
   always_comb begin
      if (state_next.burst_phase) begin
         suspect = 1'b1;
      end else if (!state_next.burst_ended) begin
         suspect = 1'b0;
      end else if (just_ended) begin
         suspect = cfg.settle_ms != 32'd0;
      end else begin
         suspect = since_end < cfg.settle_ms;
      end
   end

endmodule

### rtl/core/cell_balance_poll_sequencer.sv
// Cell balance poll sequencer: the top level.
// Each req transaction is one poll tick and yields one poll frame on rsp, or none when
// the module count is zero. Throughput is one transaction per clock cycle while rsp is not
// held: a tick is held in an input register, the duty machine and frame bytes are worked
// out in one pass of compare and select logic (two 32-bit subtract-compares set the critical
// path), and the frame lands in the result register, from which it is presented on rsp.
// A frame left waiting on rsp holds the tick in the input register.
// req_ready stays high while the result register is free or being taken in that cycle.
// Configuration is written through the csr port, registers at byte addresses 4*i.
`timescale 1ns / 1ps
`include "cell_balance_poll_sequencer_macros.svh"

module cell_balance_poll_sequencer #(
   parameter int NO_READING_MV = 10000,
   parameter int MAX_MODULES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [13:0] req_highest_mv,
   input  logic [13:0] req_lowest_mv,
   input  logic        req_all_reported,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_frame_id,
   output logic [7:0]  rsp_byte0,
   output logic [7:0]  rsp_byte1,
   output logic [7:0]  rsp_byte2,
   output logic [7:0]  rsp_byte3,
   output logic [7:0]  rsp_byte4,
   output logic [7:0]  rsp_byte5,
   output logic [7:0]  rsp_byte6,
   output logic        rsp_balancing_active,
   output logic        rsp_readings_suspect,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [4:0] MaxCount = 5'(MAX_MODULES);

   cbps_pkg::cfg_type        cfg;
   cbps_pkg::duty_state_type duty_ff, duty_in, duty_next;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [31:0] now_ff;
   logic [13:0] highest_ff, lowest_ff;
   logic        all_ff;

   // sequencing state
   logic [3:0] next_module_ff, next_module_in;
   logic [3:0] poll_cycle_ff, poll_cycle_in;
   logic       in_startup_ff, in_startup_in;
   logic       sweep_balancing_ff, sweep_balancing_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] frame_id_ff, frame_id_in;
   logic [7:0] byte0_ff, byte0_in;
   logic [7:0] byte1_ff, byte1_in;
   logic [7:0] byte4_ff, byte4_in;
   logic [7:0] byte5_ff, byte5_in;
   logic [7:0] byte6_ff, byte6_in;
   logic       bal_ff, bal_in;
   logic       suspect_ff;
   logic       suspect;

   logic       take, advance, emit, sweep_start, wrap, mark, bal;
   logic [4:0] count, mod_inc;
   logic [3:0] nm, pc;

   cbps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cbps_duty #(
      .NO_READING_MV (NO_READING_MV)
   ) u_duty (
      .cfg          (cfg),
      .sweep_start  (sweep_start),
      .now_ms       (now_ff),
      .highest_mv   (highest_ff),
      .lowest_mv    (lowest_ff),
      .all_reported (all_ff),
      .state_cur    (duty_ff),
      .state_next   (duty_next),
      .suspect      (suspect)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign count       = (cfg.module_count > MaxCount) ? MaxCount : cfg.module_count;
   assign emit        = count != 5'd0;
   assign nm          = ({1'b0, next_module_ff} >= count) ? 4'd0 : next_module_ff;
   assign sweep_start = nm == 4'd0;
   assign pc          = (sweep_start && poll_cycle_ff == cbps_pkg::CYCLE_WRAP) ? 4'd0
                                                                               : poll_cycle_ff;
   assign mod_inc     = {1'b0, nm} + 5'd1;
   assign wrap        = mod_inc >= count;
   assign mark        = in_startup_ff && (pc == cbps_pkg::STARTUP_EXIT_CYCLE);
   assign bal         = sweep_start ? duty_next.burst_phase : sweep_balancing_ff;

   always_comb begin
      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? emit : (rsp_ready ? 1'b0 : rsp_valid_ff);

      next_module_in     = next_module_ff;
      poll_cycle_in      = poll_cycle_ff;
      in_startup_in      = in_startup_ff;
      sweep_balancing_in = sweep_balancing_ff;
      duty_in            = duty_ff;
      if (advance && emit) begin
         next_module_in     = wrap ? 4'd0 : mod_inc[3:0];
         poll_cycle_in      = wrap ? pc + 4'd1 : pc;
         in_startup_in      = (wrap && mark) ? 1'b0 : in_startup_ff;
         sweep_balancing_in = bal;
         duty_in            = duty_next;
      end

      frame_id_in = cbps_pkg::FRAME_ID_BASE | {4'd0, nm};
      byte0_in    = bal ? duty_next.target_mv[7:0] : cbps_pkg::IDLE_TARGET_LO;
      byte1_in    = bal ? duty_next.target_mv[15:8] : cbps_pkg::IDLE_TARGET_HI;
      byte4_in    = in_startup_ff ? cbps_pkg::CMD_STARTUP
                                  : (bal ? cbps_pkg::CMD_BALANCE_ON : cbps_pkg::CMD_BALANCE_OFF);
      byte5_in    = in_startup_ff ? 8'd0 : cbps_pkg::RUN_FLAG;
      byte6_in    = {pc, 4'd0} | (mark ? cbps_pkg::STARTUP_MARK : 8'd0);
      bal_in      = bal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         next_module_ff           <= 4'd0;
         poll_cycle_ff            <= 4'd0;
         in_startup_ff            <= 1'b1;
         sweep_balancing_ff       <= 1'b0;
         duty_ff.burst_phase      <= 1'b0;
         duty_ff.phase_start_ms   <= 32'd0;
         duty_ff.burst_end_ms     <= 32'd0;
         duty_ff.burst_ended      <= 1'b0;
         duty_ff.target_mv        <= 16'd0;
      end else begin
         in_valid_ff        <= in_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
         next_module_ff     <= next_module_in;
         poll_cycle_ff      <= poll_cycle_in;
         in_startup_ff      <= in_startup_in;
         sweep_balancing_ff <= sweep_balancing_in;
         duty_ff            <= duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff     <= req_now_ms;
         highest_ff <= req_highest_mv;
         lowest_ff  <= req_lowest_mv;
         all_ff     <= req_all_reported;
      end
      if (advance && emit) begin
         frame_id_ff <= frame_id_in;
         byte0_ff    <= byte0_in;
         byte1_ff    <= byte1_in;
         byte4_ff    <= byte4_in;
         byte5_ff    <= byte5_in;
         byte6_ff    <= byte6_in;
         bal_ff      <= bal_in;
         suspect_ff  <= suspect;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_id         = frame_id_ff;
   assign rsp_byte0            = byte0_ff;
   assign rsp_byte1            = byte1_ff;
   assign rsp_byte2            = 8'd0;
   assign rsp_byte3            = 8'd0;
   assign rsp_byte4            = byte4_ff;
   assign rsp_byte5            = byte5_ff;
   assign rsp_byte6            = byte6_ff;
   assign rsp_balancing_active = bal_ff;
   assign rsp_readings_suspect = suspect_ff;

   `CBPS_ASSERT_NEXT(a_emit_gives_rsp, clock, reset, advance && emit, rsp_valid_ff, "frame lost")
   `CBPS_ASSERT_NEXT(a_startup_once, clock, reset, !in_startup_ff, !in_startup_ff, "startup re-entered")
   `CBPS_ASSERT_NOW(a_burst_matches_sweep, clock, reset, 1'b1, duty_ff.burst_phase == sweep_balancing_ff, "burst and sweep flag disagree")
   `CBPS_ASSERT_NOW(a_balance_suspect, clock, reset, rsp_valid_ff && bal_ff, suspect_ff, "balancing frame not suspect")

endmodule

### dv/tb.sv
// Self-checking testbench for the cell balance poll sequencer: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb;

   localparam int NO_READING   = 10000;
   localparam int MODULE_LIMIT = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [13:0] highest_mv;
      logic [13:0] lowest_mv;
      logic        all_reported;
   } tick_type;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] byte4;
      logic [7:0] byte5;
      logic [7:0] byte6;
      logic       balancing_active;
      logic       readings_suspect;
   } frame_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_now_ms;
   logic [13:0] req_highest_mv;
   logic [13:0] req_lowest_mv;
   logic        req_all_reported;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_frame_id;
   logic [7:0]  rsp_byte0;
   logic [7:0]  rsp_byte1;
   logic [7:0]  rsp_byte2;
   logic [7:0]  rsp_byte3;
   logic [7:0]  rsp_byte4;
   logic [7:0]  rsp_byte5;
   logic [7:0]  rsp_byte6;
   logic        rsp_balancing_active;
   logic        rsp_readings_suspect;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   cbps_pkg::cfg_type        shadow_cfg;
   cbps_pkg::duty_state_type duty;
   logic [3:0]               mod_idx;
   logic [3:0]               cycle_nib;
   logic                     startup;
   logic                     sweep_bal;

   tick_type    ticks_pending[$];
   frame_type   frames_due[$];
   tick_type    drive_tick;
   logic [31:0] sim_ms;
   logic [31:0] csr_expect;
   bit          req_taken;
   bit          drained;
   bit          rsp_hold;
   bit          holdoff_go;
   int          send_idle_pct;
   int          stall_pct;
   int          cycle_count;
   int          fault_count;
   int          ticks_accepted;
   int          silent_ticks;
   int          frames_checked;
   int          csr_reads;
   int          input_stalls;
   int          settings_run;

   cell_balance_poll_sequencer #(
      .NO_READING_MV(NO_READING),
      .MAX_MODULES  (MODULE_LIMIT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_highest_mv      (req_highest_mv),
      .req_lowest_mv       (req_lowest_mv),
      .req_all_reported    (req_all_reported),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_frame_id        (rsp_frame_id),
      .rsp_byte0           (rsp_byte0),
      .rsp_byte1           (rsp_byte1),
      .rsp_byte2           (rsp_byte2),
      .rsp_byte3           (rsp_byte3),
      .rsp_byte4           (rsp_byte4),
      .rsp_byte5           (rsp_byte5),
      .rsp_byte6           (rsp_byte6),
      .rsp_balancing_active(rsp_balancing_active),
      .rsp_readings_suspect(rsp_readings_suspect),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic string show_frame(input frame_type f);
      return $sformatf("id=%h bytes=%h %h %h %h %h %h %h bal=%b suspect=%b", f.frame_id,
         f.byte0, f.byte1, f.byte2, f.byte3, f.byte4, f.byte5, f.byte6,
         f.balancing_active, f.readings_suspect);
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   // Returns 1 with the frame when the tick yields one; updates the predictor state.
   function automatic bit poll_frame_for(input tick_type t, output frame_type f);
      int          count;
      logic [31:0] elapsed;
      logic        can_start;
      logic        suspect;
      logic [7:0]  b6;
      f = '0;
      count = (int'(shadow_cfg.module_count) > MODULE_LIMIT) ?
              MODULE_LIMIT : int'(shadow_cfg.module_count);
      if (count == 0) begin
         return 1'b0;
      end
      if (int'(mod_idx) >= count) begin
         mod_idx = '0;
      end
      if (mod_idx == 4'd0) begin
         if (cycle_nib == cbps_pkg::CYCLE_WRAP) begin
            cycle_nib = '0;
         end
         elapsed = t.now_ms - duty.phase_start_ms;
         if (!shadow_cfg.balance_enable) begin
            duty.burst_phase = 1'b0;
         end else if (duty.burst_phase) begin
            if (elapsed >= shadow_cfg.burst_ms) begin
               duty.burst_phase    = 1'b0;
               duty.phase_start_ms = t.now_ms;
               duty.burst_end_ms   = t.now_ms;
               duty.burst_ended    = 1'b1;
            end
         end else if (elapsed >= shadow_cfg.rest_ms) begin
            can_start = t.all_reported && (t.highest_mv != 14'd0) &&
                        (int'(t.lowest_mv) != NO_READING) && (t.highest_mv >= t.lowest_mv) &&
                        (t.highest_mv > shadow_cfg.balance_start_mv) &&
                        ((t.highest_mv - t.lowest_mv) > shadow_cfg.spread_hysteresis_mv);
            if (can_start) begin
               duty.target_mv   = 16'(t.lowest_mv) + 16'(shadow_cfg.target_offset_mv);
               duty.burst_phase = 1'b1;
            end
            duty.phase_start_ms = t.now_ms;
         end
         sweep_bal = duty.burst_phase;
      end

      elapsed = t.now_ms - duty.burst_end_ms;
      if (duty.burst_phase) begin
         suspect = 1'b1;
      end else if (!duty.burst_ended) begin
         suspect = 1'b0;
      end else begin
         suspect = elapsed < shadow_cfg.settle_ms;
      end

      b6 = {cycle_nib, 4'h0};
      if (startup && cycle_nib == cbps_pkg::STARTUP_EXIT_CYCLE) begin
         b6 = b6 + cbps_pkg::STARTUP_MARK;
      end

      f.frame_id         = cbps_pkg::FRAME_ID_BASE | {4'h0, mod_idx};
      f.byte0            = sweep_bal ? duty.target_mv[7:0] : cbps_pkg::IDLE_TARGET_LO;
      f.byte1            = sweep_bal ? duty.target_mv[15:8] : cbps_pkg::IDLE_TARGET_HI;
      f.byte2            = 8'h00;
      f.byte3            = 8'h00;
      f.byte4            = startup ? cbps_pkg::CMD_STARTUP
                                   : (sweep_bal ? cbps_pkg::CMD_BALANCE_ON
                                                : cbps_pkg::CMD_BALANCE_OFF);
      f.byte5            = startup ? 8'h00 : cbps_pkg::RUN_FLAG;
      f.byte6            = b6;
      f.balancing_active = sweep_bal;
      f.readings_suspect = suspect;

      if (int'(mod_idx) + 1 >= count) begin
         mod_idx = '0;
         if (startup && cycle_nib == cbps_pkg::STARTUP_EXIT_CYCLE) begin
            startup = 1'b0;
         end
         cycle_nib = cycle_nib + 4'd1;
      end else begin
         mod_idx = mod_idx + 4'd1;
      end
      return 1'b1;
   endfunction

   // tick driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_tick = ticks_pending.pop_front();
            req_now_ms       <= drive_tick.now_ms;
            req_highest_mv   <= drive_tick.highest_mv;
            req_lowest_mv    <= drive_tick.lowest_mv;
            req_all_reported <= drive_tick.all_reported;
            req_valid        <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // frame sink
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin : rsp_holdoff
      wait (holdoff_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor, predictor and checker
   always @(posedge clock) begin
      tick_type  acc_tick;
      frame_type exp_frame;
      frame_type got_frame;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
                  frames_due.size());
         $display("status: fail");
         $finish;
      end else begin
         req_taken = 1'b0;
         if (reset) begin
            shadow_cfg.module_count         = cbps_pkg::RST_MODULE_COUNT;
            shadow_cfg.balance_enable       = cbps_pkg::RST_BALANCE_ENABLE;
            shadow_cfg.balance_start_mv     = cbps_pkg::RST_BALANCE_START;
            shadow_cfg.spread_hysteresis_mv = cbps_pkg::RST_SPREAD_HYST;
            shadow_cfg.target_offset_mv     = cbps_pkg::RST_TARGET_OFFSET;
            shadow_cfg.burst_ms             = cbps_pkg::RST_BURST_MS;
            shadow_cfg.rest_ms              = cbps_pkg::RST_REST_MS;
            shadow_cfg.settle_ms            = cbps_pkg::RST_SETTLE_MS;
            duty      = '0;
            mod_idx   = '0;
            cycle_nib = '0;
            startup   = 1'b1;
            sweep_bal = 1'b0;
         end else begin
            if (csr_psel && csr_penable && csr_pready) begin
               if (csr_pwrite) begin
                  case (cbps_pkg::csr_index_type'(csr_paddr[4:2]))
                     cbps_pkg::REG_MODULE_COUNT:
                        shadow_cfg.module_count = csr_pwdata[4:0];
                     cbps_pkg::REG_BALANCE_ENABLE:
                        shadow_cfg.balance_enable = csr_pwdata[0];
                     cbps_pkg::REG_BALANCE_START:
                        shadow_cfg.balance_start_mv = csr_pwdata[13:0];
                     cbps_pkg::REG_SPREAD_HYST:
                        shadow_cfg.spread_hysteresis_mv = csr_pwdata[13:0];
                     cbps_pkg::REG_TARGET_OFFSET:
                        shadow_cfg.target_offset_mv = csr_pwdata[13:0];
                     cbps_pkg::REG_BURST_MS:
                        shadow_cfg.burst_ms = csr_pwdata;
                     cbps_pkg::REG_REST_MS:
                        shadow_cfg.rest_ms = csr_pwdata;
                     default:
                        shadow_cfg.settle_ms = csr_pwdata;
                  endcase
               end else begin
                  case (cbps_pkg::csr_index_type'(csr_paddr[4:2]))
                     cbps_pkg::REG_MODULE_COUNT:
                        csr_expect = 32'(shadow_cfg.module_count);
                     cbps_pkg::REG_BALANCE_ENABLE:
                        csr_expect = 32'(shadow_cfg.balance_enable);
                     cbps_pkg::REG_BALANCE_START:
                        csr_expect = 32'(shadow_cfg.balance_start_mv);
                     cbps_pkg::REG_SPREAD_HYST:
                        csr_expect = 32'(shadow_cfg.spread_hysteresis_mv);
                     cbps_pkg::REG_TARGET_OFFSET:
                        csr_expect = 32'(shadow_cfg.target_offset_mv);
                     cbps_pkg::REG_BURST_MS:
                        csr_expect = shadow_cfg.burst_ms;
                     cbps_pkg::REG_REST_MS:
                        csr_expect = shadow_cfg.rest_ms;
                     default:
                        csr_expect = shadow_cfg.settle_ms;
                  endcase
                  csr_reads++;
                  if (csr_prdata !== csr_expect) begin
                     note_fault($sformatf("csr read at %h: expected %h, got %h", csr_paddr,
                                          csr_expect, csr_prdata));
                  end
               end
            end

            if (req_valid && !req_ready) begin
               input_stalls++;
            end
            if (req_valid && req_ready) begin
               req_taken = 1'b1;
               ticks_accepted++;
               acc_tick = {req_now_ms, req_highest_mv, req_lowest_mv, req_all_reported};
               if (poll_frame_for(acc_tick, exp_frame)) begin
                  frames_due.push_back(exp_frame);
               end else begin
                  silent_ticks++;
               end
            end

            if (rsp_valid && rsp_ready) begin
               got_frame = {rsp_frame_id, rsp_byte0, rsp_byte1, rsp_byte2, rsp_byte3, rsp_byte4,
                            rsp_byte5, rsp_byte6, rsp_balancing_active, rsp_readings_suspect};
               if (frames_due.size() == 0) begin
                  note_fault($sformatf("unexpected frame %s", show_frame(got_frame)));
               end else begin
                  exp_frame = frames_due.pop_front();
                  frames_checked++;
                  if (got_frame !== exp_frame) begin
                     note_fault($sformatf("frame %0d: expected %s, got %s", frames_checked,
                                          show_frame(exp_frame), show_frame(got_frame)));
                  end
               end
            end
         end
         drained = (ticks_pending.size() == 0) && !req_valid && (frames_due.size() == 0);
      end
   end

   task automatic csr_access(input logic write, input cbps_pkg::csr_index_type idx,
                             input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_config(input cbps_pkg::cfg_type plan, input bit write_regs);
      if (write_regs) begin
         csr_access(1'b1, cbps_pkg::REG_MODULE_COUNT, 32'(plan.module_count));
         csr_access(1'b1, cbps_pkg::REG_BALANCE_ENABLE, 32'(plan.balance_enable));
         csr_access(1'b1, cbps_pkg::REG_BALANCE_START, 32'(plan.balance_start_mv));
         csr_access(1'b1, cbps_pkg::REG_SPREAD_HYST, 32'(plan.spread_hysteresis_mv));
         csr_access(1'b1, cbps_pkg::REG_TARGET_OFFSET, 32'(plan.target_offset_mv));
         csr_access(1'b1, cbps_pkg::REG_BURST_MS, plan.burst_ms);
         csr_access(1'b1, cbps_pkg::REG_REST_MS, plan.rest_ms);
         csr_access(1'b1, cbps_pkg::REG_SETTLE_MS, plan.settle_ms);
      end
      for (int i = 0; i < 8; i++) begin
         csr_access(1'b0, cbps_pkg::csr_index_type'(i), 32'h0);
      end
      settings_run++;
   endtask

   task automatic push_tick(input logic [31:0] now, input int hi, input int lo,
                            input logic all);
      tick_type t;
      t.now_ms       = now;
      t.highest_mv   = 14'(hi);
      t.lowest_mv    = 14'(lo);
      t.all_reported = all;
      ticks_pending.push_back(t);
   endtask

   task automatic wait_drained;
      @(negedge clock);
      while (!drained) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mostly plausible pack readings on a rising clock, with some broken or wild ticks.
   task automatic random_ticks(input int n);
      tick_type t;
      int       lo_v;
      repeat (n) begin
         sim_ms = sim_ms + $urandom_range(12);
         lo_v = $urandom_range(4200, 2500);
         t.now_ms       = sim_ms;
         t.lowest_mv    = 14'(lo_v);
         t.highest_mv   = 14'(lo_v + $urandom_range(300));
         t.all_reported = 1'b1;
         if ($urandom_range(99) < 25) begin
            case ($urandom_range(5))
               0: t.all_reported = 1'b0;
               1: t.highest_mv = 14'd0;
               2: t.lowest_mv = 14'(NO_READING);
               3: t.highest_mv = t.lowest_mv - 14'(1 + $urandom_range(200));
               4: begin
                  sim_ms = $urandom;
                  t.now_ms       = sim_ms;
                  t.highest_mv   = 14'($urandom);
                  t.lowest_mv    = 14'($urandom);
                  t.all_reported = 1'($urandom);
               end
               default: begin
                  sim_ms   = sim_ms - $urandom_range(50);
                  t.now_ms = sim_ms;
               end
            endcase
         end
         ticks_pending.push_back(t);
      end
   endtask

   initial begin : stimulus
      cbps_pkg::cfg_type plan;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_ms       = '0;
      req_highest_mv   = '0;
      req_lowest_mv    = '0;
      req_all_reported = 1'b0;
      rsp_ready        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // reset settings: a sweep inside the first rest period, then a burst start
      plan = '0;
      apply_config(plan, 1'b0);
      push_tick(32'd0, 16383, 0, 1'b1);
      for (int i = 1; i < 6; i++) push_tick(32'(i), 0, NO_READING, 1'b0);
      for (int i = 0; i < 6; i++) push_tick(32'(60000 + i), 4100, 3000, 1'b1);
      wait_drained;

      // no modules: ticks are taken but nothing comes out
      plan.module_count         = 5'd0;
      plan.balance_enable       = 1'b1;
      plan.balance_start_mv     = cbps_pkg::RST_BALANCE_START;
      plan.spread_hysteresis_mv = cbps_pkg::RST_SPREAD_HYST;
      plan.target_offset_mv     = cbps_pkg::RST_TARGET_OFFSET;
      plan.burst_ms             = cbps_pkg::RST_BURST_MS;
      plan.rest_ms              = cbps_pkg::RST_REST_MS;
      plan.settle_ms            = cbps_pkg::RST_SETTLE_MS;
      apply_config(plan, 1'b1);
      push_tick(32'd70000, 4100, 3000, 1'b1);
      push_tick(32'd70001, 4100, 3000, 1'b1);
      wait_drained;

      // one module: burst across the clock wrap ending at time zero, then unusable data
      plan.module_count         = 5'd1;
      plan.balance_start_mv     = 14'd100;
      plan.spread_hysteresis_mv = 14'd0;
      plan.target_offset_mv     = 14'd16383;
      plan.burst_ms             = 32'd16;
      plan.rest_ms              = 32'd0;
      plan.settle_ms            = 32'd5;
      apply_config(plan, 1'b1);
      push_tick(32'hFFFF_FFE0, 16383, 0, 1'b1);
      push_tick(32'hFFFF_FFF0, 16383, 0, 1'b1);
      push_tick(32'hFFFF_FFF8, 16383, 0, 1'b1);
      push_tick(32'd0, 16383, 0, 1'b1);
      push_tick(32'd3, 16383, 0, 1'b0);
      push_tick(32'd4, 0, 0, 1'b1);
      push_tick(32'd5, 16383, NO_READING, 1'b1);
      push_tick(32'd6, 5, 6, 1'b1);
      push_tick(32'd7, 100, 0, 1'b1);
      push_tick(32'd8, 200, 200, 1'b1);
      wait_drained;
      sim_ms = 32'd8;

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         plan.module_count         = 5'($urandom_range(16, 1));
         plan.balance_enable       = ($urandom_range(3) != 0);
         plan.balance_start_mv     = 14'($urandom_range(4000, 3000));
         plan.spread_hysteresis_mv = 14'($urandom_range(100));
         plan.target_offset_mv     = 14'($urandom_range(100));
         plan.burst_ms             = $urandom_range(40);
         plan.rest_ms              = $urandom_range(40);
         plan.settle_ms            = $urandom_range(60);
         case (phase)
            1: plan = '1;
            2: begin
               plan = '0;
               plan.module_count = 5'd1;
            end
            3: plan.module_count = 5'd16;
            4: plan = cbps_pkg::cfg_type'({$urandom, $urandom, $urandom, $urandom,
                                           16'($urandom)});
            5: plan.module_count = 5'd0;
            default: ;
         endcase
         apply_config(plan, 1'b1);
         random_ticks((phase == 5) ? 20 : 140);
         if (phase == 0) begin
            holdoff_go = 1'b1;
         end
         wait_drained;
      end

      repeat (8) @(negedge clock);
      $display("%0d poll ticks over %0d register settings: %0d frames checked, %0d ticks silent",
               ticks_accepted, settings_run, frames_checked, silent_ticks);
      $display("%0d register reads compared, %0d cycles of input back-pressure, %0d faults",
               csr_reads, input_stalls, fault_count);
      if (fault_count == 0 && frames_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
